// ===== sv/srt_pkg.sv =====
// shared constants, types and control bundles for the shortest-remaining-time scheduler
`default_nettype none
package srt_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int TIME_BITS  = 16;
   localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
   localparam int WORK_BITS  = 16;
   localparam int FIELD_BITS = 16;
   localparam int WIDE_BITS  = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
   localparam int COUNT_BITS = 5;
   localparam int SUM_BITS   = 32;
   localparam int CMP_BITS   = 8;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // best candidate travelling down the row of cells
   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] idx;
      logic [WORK_BITS-1:0] rem;
      logic [TIME_BITS-1:0] arrival;
      logic [WORK_BITS-1:0] burst;
   } token_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                  load;
      logic [3:0]            load_slot;
      logic [TIME_BITS-1:0]  load_arrival;
      logic [WORK_BITS-1:0]  load_burst;
      logic                  dec;
      logic [SLOT_BITS-1:0]  dec_idx;
      logic [TIME_BITS-1:0]  now;
      logic [COUNT_BITS-1:0] proc_count;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== sv/shortest_remaining_time_scheduler.sv =====
// top level: item handshake, tick sequencing, time keeping, totals and result register
// A load item writes its slot at the accepting edge, and its result goes to the output
// register at once. A tick item sends the search token down the row of slot cells one
// cell per cycle; then the calc state forms the finish, turnaround and waiting times,
// and the emit state updates the chosen slot, the clock and the totals while the
// result is registered. A new item is taken only when the block is idle and the result
// register is free or being emptied. The output register holds a finished result while
// the next item is accepted.
`default_nettype none
module shortest_remaining_time_scheduler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [srt_pkg::COUNT_BITS-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_op,
   input  wire logic [3:0]                       req_slot,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]   req_arrival,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]   req_burst,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [3:0]                            rsp_chosen_slot,
   output logic                                  rsp_idle,
   output logic                                  rsp_finished,
   output logic [srt_pkg::FIELD_BITS-1:0]        rsp_finish_time,
   output logic [srt_pkg::FIELD_BITS-1:0]        rsp_waiting,
   output logic [srt_pkg::FIELD_BITS-1:0]        rsp_turnaround,
   output logic [srt_pkg::COUNT_BITS-1:0]        rsp_done_count,
   output logic                                  rsp_all_done,
   output logic [srt_pkg::SUM_BITS-1:0]          rsp_total_waiting,
   output logic [srt_pkg::SUM_BITS-1:0]          rsp_total_turnaround
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_CALC   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [srt_pkg::COUNT_BITS-1:0]  pc_ff;
   logic [srt_pkg::TIME_BITS-1:0]   now_ff, now_in, now_inc;
   logic [srt_pkg::COUNT_BITS-1:0]  done_ff, done_in;
   logic [srt_pkg::SUM_BITS-1:0]    tw_ff, tw_in;
   logic [srt_pkg::SUM_BITS-1:0]    tt_ff, tt_in;

   logic                            found_ff;
   logic [srt_pkg::SLOT_BITS-1:0]   chosen_ff;
   logic                            fin_ff;
   logic [srt_pkg::WIDE_BITS-1:0]   ftime_ff, turn_ff, wait_ff;
   logic [srt_pkg::WIDE_BITS-1:0]   ftime_w, arr_w, burst_w, turn_w, wait_w;

   logic                            rsp_valid_ff;
   logic [3:0]                      chosen_out_ff;
   logic                            idle_out_ff, fin_out_ff, all_done_ff;
   logic [srt_pkg::FIELD_BITS-1:0]  ftime_out_ff, wait_out_ff, turn_out_ff;
   logic [srt_pkg::COUNT_BITS-1:0]  done_out_ff;
   logic [srt_pkg::SUM_BITS-1:0]    tw_out_ff, tt_out_ff;

   logic                            accept, accept_load, accept_tick;
   logic                            out_free, emit;
   logic [srt_pkg::SUM_BITS:0]      tw_sum, tt_sum;
   srt_pkg::cell_ctl_type           ctl;
   srt_pkg::token_type              best;
   logic                            chain_done;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE) || !out_free;
   assign accept      = req_valid && !req_stall;
   assign accept_load = accept && (req_op == srt_pkg::OP_LOAD);
   assign accept_tick = accept && (req_op == srt_pkg::OP_TICK);
   assign emit        = (state_ff == ST_EMIT) && out_free;

   assign now_inc = (now_ff == '1) ? now_ff : now_ff + srt_pkg::TIME_BITS'(1);

   always_comb begin
      ctl              = '0;
      ctl.load         = accept_load;
      ctl.load_slot    = req_slot;
      ctl.load_arrival = srt_pkg::TIME_BITS'(req_arrival);
      ctl.load_burst   = srt_pkg::WORK_BITS'(req_burst);
      ctl.dec          = emit && found_ff;
      ctl.dec_idx      = chosen_ff;
      ctl.now          = now_ff;
      ctl.proc_count   = pc_ff;
   end

   srt_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .start (accept_tick),
      .best  (best),
      .done  (chain_done)
   );

   // finish-time arithmetic on the winner, clamped at zero
   assign ftime_w = srt_pkg::WIDE_BITS'(now_inc);
   assign arr_w   = srt_pkg::WIDE_BITS'(best.arrival);
   assign burst_w = srt_pkg::WIDE_BITS'(best.burst);
   assign turn_w  = (ftime_w > arr_w) ? ftime_w - arr_w : '0;
   assign wait_w  = (turn_w > burst_w) ? turn_w - burst_w : '0;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         found_ff  <= best.found;
         chosen_ff <= best.found ? best.idx : '0;
         fin_ff    <= best.found && (best.rem == srt_pkg::WORK_BITS'(1));
         ftime_ff  <= ftime_w;
         turn_ff   <= turn_w;
         wait_ff   <= wait_w;
      end
   end

   assign tw_sum = {1'b0, tw_ff} + {1'b0, srt_pkg::SUM_BITS'(wait_ff)};
   assign tt_sum = {1'b0, tt_ff} + {1'b0, srt_pkg::SUM_BITS'(turn_ff)};

   always_comb begin
      state_in = state_ff;
      now_in   = now_ff;
      done_in  = done_ff;
      tw_in    = tw_ff;
      tt_in    = tt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_tick) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (chain_done) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
               now_in   = now_inc;
               if (fin_ff) begin
                  if (done_ff != '1) begin
                     done_in = done_ff + srt_pkg::COUNT_BITS'(1);
                  end
                  tw_in = tw_sum[srt_pkg::SUM_BITS] ? '1 : tw_sum[srt_pkg::SUM_BITS-1:0];
                  tt_in = tt_sum[srt_pkg::SUM_BITS] ? '1 : tt_sum[srt_pkg::SUM_BITS-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= srt_pkg::COUNT_BITS'(1);
         now_ff       <= '0;
         done_ff      <= '0;
         tw_ff        <= '0;
         tt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff   <= now_in;
         done_ff  <= done_in;
         tw_ff    <= tw_in;
         tt_ff    <= tt_in;
         if (csr_write) begin
            pc_ff <= csr_wdata;
         end
         if (accept_load || emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register: a load shows the current totals, a tick its outcome
   always_ff @(posedge clock) begin
      if (accept_load) begin
         chosen_out_ff <= '0;
         idle_out_ff   <= 1'b0;
         fin_out_ff    <= 1'b0;
         ftime_out_ff  <= '0;
         wait_out_ff   <= '0;
         turn_out_ff   <= '0;
         done_out_ff   <= done_ff;
         all_done_ff   <= (done_ff == pc_ff);
         tw_out_ff     <= tw_ff;
         tt_out_ff     <= tt_ff;
      end else if (emit) begin
         chosen_out_ff <= 4'(chosen_ff);
         idle_out_ff   <= !found_ff;
         fin_out_ff    <= fin_ff;
         ftime_out_ff  <= fin_ff ? srt_pkg::FIELD_BITS'(ftime_ff) : '0;
         wait_out_ff   <= fin_ff ? srt_pkg::FIELD_BITS'(wait_ff) : '0;
         turn_out_ff   <= fin_ff ? srt_pkg::FIELD_BITS'(turn_ff) : '0;
         done_out_ff   <= done_in;
         all_done_ff   <= (done_in == pc_ff);
         tw_out_ff     <= tw_in;
         tt_out_ff     <= tt_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chosen_slot      = chosen_out_ff;
   assign rsp_idle             = idle_out_ff;
   assign rsp_finished         = fin_out_ff;
   assign rsp_finish_time      = ftime_out_ff;
   assign rsp_waiting          = wait_out_ff;
   assign rsp_turnaround       = turn_out_ff;
   assign rsp_done_count       = done_out_ff;
   assign rsp_all_done         = all_done_ff;
   assign rsp_total_waiting    = tw_out_ff;
   assign rsp_total_turnaround = tt_out_ff;

   // the search token only ever comes out while a tick is searching
   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> (state_ff == ST_SEARCH))
      else $error("search token left the row outside a search");

   // an accepted tick starts a search on the next cycle
   a_tick_searches: assert property (@(posedge clock) disable iff (reset)
      accept_tick |=> (state_ff == ST_SEARCH))
      else $error("tick item did not start a search");

   // the done count never goes down
   a_done_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (done_ff >= $past(done_ff)))
      else $error("done count decreased");

   // an idle tick cannot finish a slot
   a_idle_not_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_idle && rsp_finished))
      else $error("result is both idle and finished");

   // time only moves when a tick result is registered
   a_time_on_emit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(emit)) |-> $stable(now_ff))
      else $error("time advanced without a tick result");

endmodule
`default_nettype wire

// ===== sv/srt_cell.sv =====
// one process slot: holds its times and passes the best candidate on to the next cell
`default_nettype none
module srt_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [srt_pkg::SLOT_BITS-1:0] cell_idx,
   input  wire srt_pkg::cell_ctl_type        ctl,
   input  wire srt_pkg::token_type           tok_in,
   input  wire logic                         tok_in_valid,
   output srt_pkg::token_type                tok_out,
   output logic                              tok_out_valid
);

   logic [srt_pkg::TIME_BITS-1:0] arrival_ff;
   logic [srt_pkg::WORK_BITS-1:0] burst_ff;
   logic [srt_pkg::WORK_BITS-1:0] rem_ff;
   srt_pkg::token_type            tok_ff;
   srt_pkg::token_type            tok_in_mux;
   logic                          valid_ff;
   logic                          in_range;
   logic                          eligible;
   logic                          win;
   logic                          load_hit;
   logic                          dec_hit;

   assign in_range = srt_pkg::CMP_BITS'(cell_idx) < srt_pkg::CMP_BITS'(ctl.proc_count);
   assign eligible = in_range && (arrival_ff <= ctl.now) && (rem_ff != '0);
   // strict compare keeps the earlier slot on a tie
   assign win      = eligible && (!tok_in.found || (rem_ff < tok_in.rem));
   assign load_hit = ctl.load &&
                     (srt_pkg::CMP_BITS'(ctl.load_slot) == srt_pkg::CMP_BITS'(cell_idx));
   assign dec_hit  = ctl.dec && (ctl.dec_idx == cell_idx);

   always_comb begin
      tok_in_mux = tok_in;
      if (win) begin
         tok_in_mux.found   = 1'b1;
         tok_in_mux.idx     = cell_idx;
         tok_in_mux.rem     = rem_ff;
         tok_in_mux.arrival = arrival_ff;
         tok_in_mux.burst   = burst_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         arrival_ff <= ctl.load_arrival;
         burst_ff   <= ctl.load_burst;
         rem_ff     <= ctl.load_burst;
      end else if (dec_hit) begin
         rem_ff <= rem_ff - srt_pkg::WORK_BITS'(1);
      end
      if (tok_in_valid) begin
         tok_ff <= tok_in_mux;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_in_valid;
      end
   end

   assign tok_out       = tok_ff;
   assign tok_out_valid = valid_ff;

endmodule
`default_nettype wire

// ===== sv/srt_chain.sv =====
// row of slot cells; a search token enters at slot zero and leaves after the last slot
`default_nettype none
module srt_chain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srt_pkg::cell_ctl_type ctl,
   input  wire logic                  start,
   output srt_pkg::token_type         best,
   output logic                       done
);

   srt_pkg::token_type tok [srt_pkg::NUM_SLOTS+1];
   logic               tok_valid [srt_pkg::NUM_SLOTS+1];

   assign tok[0]       = '0;
   assign tok_valid[0] = start;

   for (genvar i = 0; i < srt_pkg::NUM_SLOTS; i++) begin : g_cell
      srt_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_idx      (srt_pkg::SLOT_BITS'(i)),
         .ctl           (ctl),
         .tok_in        (tok[i]),
         .tok_in_valid  (tok_valid[i]),
         .tok_out       (tok[i+1]),
         .tok_out_valid (tok_valid[i+1])
      );
   end

   assign best = tok[srt_pkg::NUM_SLOTS];
   assign done = tok_valid[srt_pkg::NUM_SLOTS];

endmodule
`default_nettype wire
